// ===== hdl/flxobs_pkg.sv =====
// Shared types, constants, rounding and saturation helpers and the arctangent table for the flux observer.
package flxobs_pkg;

	// Limit bounds, iteration counts, the gain cap and the period reset value
	localparam int unsigned FLUX_LIMIT_MAX = 268435456;
	localparam int unsigned FLUX_LIMIT_MIN = 1048576;
	localparam int unsigned CORDIC_STEPS   = 24;
	localparam int unsigned DIV_STEPS      = 24;
	localparam logic [31:0] F_CAP          = 32'h7FFF_FFFF;
	localparam logic [15:0] PERIOD_RESET   = 16'd13422;

	typedef logic signed [71:0] wide_t;
	typedef logic signed [32:0] op_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_ADAPT,
		MODE_CLAMP,
		MODE_ORTEGA
	} obs_mode_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_RES,
		REG_LD,
		REG_LQ,
		REG_PERIOD,
		REG_NOMINAL,
		REG_LIM_GAIN,
		REG_ORT_GAIN
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_AN1, ST_AN2, ST_AN3, ST_AN4, ST_AN5, ST_AN6, ST_AN7,
		ST_EA1, ST_EA2, ST_EA3, ST_EA4, ST_EA5,
		ST_TA1, ST_TA2, ST_CL,
		ST_OQ1, ST_OQ2, ST_OQ3, ST_OQ4, ST_ODIV, ST_OADJ,
		ST_OL1, ST_OL2, ST_OL3,
		ST_OF1, ST_ON1, ST_ON2, ST_ON3, ST_ON4,
		ST_OG1, ST_OG2, ST_OG3, ST_OG4, ST_OG5,
		ST_OC1, ST_OC2, ST_OC3, ST_OANG,
		ST_CSTART, ST_CWAIT, ST_DONE
	} seq_state_t;

	// Round a right shift to nearest, ties away from zero
	function automatic wide_t rnd_sh(input wide_t x, input int unsigned s);
		wide_t m;
		wide_t r;
		m = x[71] ? -x : x;
		r = (m + (wide_t'(1) <<< (s - 1))) >>> s;
		return x[71] ? -r : r;
	endfunction

	// Saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input wide_t x);
		if (x > 72'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (x < -(72'sd2147483648))
			return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// Arctangent of 2^-i, 2^32 per turn
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		case (i)
			5'd0:  return 32'd536870912;
			5'd1:  return 32'd316933406;
			5'd2:  return 32'd167458907;
			5'd3:  return 32'd85004756;
			5'd4:  return 32'd42667331;
			5'd5:  return 32'd21354465;
			5'd6:  return 32'd10679838;
			5'd7:  return 32'd5340245;
			5'd8:  return 32'd2670163;
			5'd9:  return 32'd1335087;
			5'd10: return 32'd667544;
			5'd11: return 32'd333772;
			5'd12: return 32'd166886;
			5'd13: return 32'd83443;
			5'd14: return 32'd41722;
			5'd15: return 32'd20861;
			5'd16: return 32'd10430;
			5'd17: return 32'd5215;
			5'd18: return 32'd2608;
			5'd19: return 32'd1304;
			5'd20: return 32'd652;
			5'd21: return 32'd326;
			5'd22: return 32'd163;
			5'd23: return 32'd81;
			default: return 32'd0;
		endcase
	endfunction

endpackage

// ===== hdl/flxobs_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
module flxobs_mul (
	input  logic                clk,
	input  logic signed [32:0]  a,
	input  logic signed [32:0]  b,
	output logic signed [65:0]  prod_q
);
	import flxobs_pkg::*;

	// Register every product
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ===== hdl/flxobs_cordic.sv =====
// Iterative CORDIC vectoring unit: angle of (x, y), one step per cycle.
module flxobs_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [32:0]  x_in,
	input  logic signed [32:0]  y_in,
	output logic                done,
	output logic [15:0]         angle
);
	import flxobs_pkg::*;

	logic signed [35:0] x_q, y_q, dx, dy;
	logic [31:0]        z_q;
	logic [4:0]         step_q;
	logic               run_q, done_q;

	assign dx    = y_q >>> step_q;
	assign dy    = x_q >>> step_q;
	assign done  = done_q;
	assign angle = z_q[31:16];

	// Control: run for a fixed count of rotations, or finish without rotating on a zero vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				if (x_in == '0 && y_in == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: fold into the right half plane, then rotate toward y = 0
	always_ff @(posedge clk) begin
		if (start) begin
			if (x_in == '0 && y_in == '0) begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
			end else if (x_in[32]) begin
				x_q <= -36'(x_in);
				y_q <= -36'(y_in);
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= 36'(x_in);
				y_q <= 36'(y_in);
				z_q <= '0;
			end
		end else if (run_q) begin
			if (!y_q[35]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_lut(step_q);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_lut(step_q);
			end
		end
	end

endmodule

// ===== hdl/sensorless_flux_observer_core.sv =====
// Sensor-less stator flux observer: sequencer around a shared multiplier.
//
// Input beats arrive on s_axis: tdata carries the alpha/beta voltages and
// alpha/beta/d/q currents, tuser the injection flag. Each beat yields exactly
// one result beat on m_axis with both flux components, the flux limit and the
// rotor angle. The user must write settings on the cfg port only while the
// block is idle; the block itself does not enforce this.
// One beat is worked at a time on a single 33x33 multiplier that is reused
// step by step, then on an iterative CORDIC (24 rotations) for the angle.
// The steps depend on the mode: mode none loads the result directly, clamp
// mode integrates and clamps, adaptive-limit mode adapts the limit first, and
// Ortega mode integrates with the 24-step restoring divider of the inductance
// blend, skipped when both d/q currents are zero, and a correction when the
// flux is above nominal. A beat with injection skips the CORDIC. The next
// beat is taken in the cycle after the result is loaded (s_axis_tready is high
// only while the sequencer waits for a beat).
// Reset clears the flux, the current memory, the angle and the flux limit
// and loads the register defaults. A finished result sits in the output
// register; while the receiver stalls it holds and the sequencer waits with
// the next result until that register is free.
module sensorless_flux_observer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// v_alpha, v_beta, i_alpha, i_beta, i_direct, i_quadrature
	input  logic [95:0]   s_axis_tdata,
	// injecting
	input  logic [0:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// flux_alpha_out, flux_beta_out, flux_limit_out, rotor_angle, zero pad
	output logic [111:0]  m_axis_tdata,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [30:0]   cfg_data
);
	import flxobs_pkg::*;

	seq_state_t state_q, state_n;

	// Settings
	obs_mode_t   mode_q;
	logic [15:0] res_q, ld_q, lq_q, per_q, lgain_q, ogain_q;
	logic [30:0] nom_q;

	// Observer state
	logic signed [31:0] fa_q, fb_q;
	logic signed [15:0] pia_q, pib_q;
	logic [30:0]        limit_q;
	logic [15:0]        angle_q;

	// Latched sample
	logic signed [15:0] va_q, vb_q, ia_q, ib_q, id_q, iq_q;
	logic               inj_q;

	// Work registers
	wide_t              acc_q;
	logic [35:0]        ed_q;
	logic               neg_q;
	logic signed [32:0] emf_q;
	logic signed [26:0] ea_q, eb_q;
	logic signed [31:0] lia_q, lib_q;
	logic [30:0]        q2_q;
	logic [31:0]        sum_q, gt_q, f_q, rem_q;
	logic signed [25:0] l8_q;
	logic [23:0]        nlo_q, quo_q;
	logic [4:0]         dcnt_q;
	logic               dneg_q;
	logic               m_valid_q;
	logic [111:0]       m_data_q;

	// Shared units
	op_t                a_op, b_op;
	logic signed [65:0] prod_q;
	logic               cor_start, cor_done;
	op_t                cor_x, cor_y;
	logic [15:0]        cor_angle;

	// Combinational helpers
	wide_t        prod_w, t_dmag, t_ed, t_sum, t_r16, t_r12, t_lim, t_r23, t_r3;
	wide_t        t_r11, t_r32, t_emf, t_mag, t_nv;
	logic [31:0]  sum_n, t_f;
	logic [32:0]  t_trial, t_dv;
	logic         in_fire, out_load;
	logic signed [31:0] fa_cl, fb_cl;

	flxobs_mul u_mul (
		.clk    (clk),
		.a      (a_op),
		.b      (b_op),
		.prod_q (prod_q)
	);

	flxobs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x_in   (cor_x),
		.y_in   (cor_y),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Arithmetic around the product register
	always_comb begin
		prod_w  = wide_t'(prod_q);
		t_dmag  = (acc_q >= prod_w) ? acc_q - prod_w : prod_w - acc_q;
		t_ed    = rnd_sh(t_dmag, 28);
		t_sum   = acc_q + (prod_w <<< 32);
		t_r16   = rnd_sh(t_sum, 16);
		t_r12   = rnd_sh(t_sum, 12);
		t_lim   = neg_q ? wide_t'(limit_q) - t_r16 : wide_t'(limit_q) + t_r16;
		if (t_lim > wide_t'(FLUX_LIMIT_MAX))
			t_lim = wide_t'(FLUX_LIMIT_MAX);
		if (t_lim < wide_t'(FLUX_LIMIT_MIN))
			t_lim = wide_t'(FLUX_LIMIT_MIN);
		t_r23   = rnd_sh(prod_w, 23);
		t_r3    = rnd_sh(prod_w, 3);
		t_r11   = rnd_sh(prod_w, 11);
		t_r32   = rnd_sh(prod_w, 32);
		t_emf   = (wide_t'((state_q == ST_EA2) ? va_q : vb_q) <<< 15) - prod_w;
		t_mag   = prod_w[71] ? -prod_w : prod_w;
		t_nv    = (t_mag <<< 8) + wide_t'(sum_q);
		sum_n   = 32'(q2_q) + prod_q[31:0];
		t_trial = {rem_q, nlo_q[23]};
		t_dv    = {sum_q, 1'b0};
		t_f     = (t_r12 > wide_t'(F_CAP)) ? F_CAP : t_r12[31:0];
		fa_cl   = fa_q;
		if (wide_t'(fa_q) > wide_t'(limit_q))
			fa_cl = 32'(limit_q);
		else if (wide_t'(fa_q) < -wide_t'(limit_q))
			fa_cl = -32'(limit_q);
		fb_cl   = fb_q;
		if (wide_t'(fb_q) > wide_t'(limit_q))
			fb_cl = 32'(limit_q);
		else if (wide_t'(fb_q) < -wide_t'(limit_q))
			fb_cl = -32'(limit_q);
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					case (mode_q)
						MODE_ADAPT:  state_n = ST_AN1;
						MODE_CLAMP:  state_n = ST_EA1;
						MODE_ORTEGA: state_n = ST_OQ1;
						default:     state_n = ST_DONE;
					endcase
				end
			end
			ST_AN1:    state_n = ST_AN2;
			ST_AN2:    state_n = ST_AN3;
			ST_AN3:    state_n = ST_AN4;
			ST_AN4:    state_n = ST_AN5;
			ST_AN5:    state_n = ST_AN6;
			ST_AN6:    state_n = ST_AN7;
			ST_AN7:    state_n = ST_EA1;
			ST_EA1:    state_n = ST_EA2;
			ST_EA2:    state_n = ST_EA3;
			ST_EA3:    state_n = ST_EA4;
			ST_EA4:    state_n = ST_EA5;
			ST_EA5:    state_n = (mode_q == MODE_ORTEGA) ? ST_OF1 : ST_TA1;
			ST_TA1:    state_n = ST_TA2;
			ST_TA2:    state_n = ST_CL;
			ST_CL:     state_n = inj_q ? ST_DONE : ST_CSTART;
			ST_OQ1:    state_n = ST_OQ2;
			ST_OQ2:    state_n = ST_OQ3;
			ST_OQ3:    state_n = (sum_n == '0) ? ST_OL1 : ST_OQ4;
			ST_OQ4:    state_n = ST_ODIV;
			ST_ODIV:   state_n = (dcnt_q == 5'(DIV_STEPS - 1)) ? ST_OADJ : ST_ODIV;
			ST_OADJ:   state_n = ST_OL1;
			ST_OL1:    state_n = ST_OL2;
			ST_OL2:    state_n = ST_OL3;
			ST_OL3:    state_n = ST_EA1;
			ST_OF1:    state_n = ST_ON1;
			ST_ON1:    state_n = ST_ON2;
			ST_ON2:    state_n = ST_ON3;
			ST_ON3:    state_n = ST_ON4;
			ST_ON4:    state_n = (acc_q > prod_w) ? ST_OG1 : ST_OANG;
			ST_OG1:    state_n = ST_OG2;
			ST_OG2:    state_n = ST_OG3;
			ST_OG3:    state_n = ST_OG4;
			ST_OG4:    state_n = ST_OG5;
			ST_OG5:    state_n = ST_OC1;
			ST_OC1:    state_n = ST_OC2;
			ST_OC2:    state_n = ST_OC3;
			ST_OC3:    state_n = ST_OANG;
			ST_OANG:   state_n = inj_q ? ST_DONE : ST_CSTART;
			ST_CSTART: state_n = ST_CWAIT;
			ST_CWAIT:  state_n = cor_done ? ST_DONE : ST_CWAIT;
			ST_DONE:   state_n = out_load ? ST_IDLE : ST_DONE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: multiplier operands, handshake, CORDIC start
	always_comb begin
		a_op          = '0;
		b_op          = '0;
		s_axis_tready = (state_q == ST_IDLE);
		cor_start     = (state_q == ST_CSTART);
		cor_x         = (mode_q == MODE_ORTEGA) ? op_t'(fa_q) - op_t'(lia_q) : op_t'(fa_q);
		cor_y         = (mode_q == MODE_ORTEGA) ? op_t'(fb_q) - op_t'(lib_q) : op_t'(fb_q);
		case (state_q)
			ST_AN1, ST_ON1: begin
				a_op = op_t'(fa_q);
				b_op = op_t'(fa_q);
			end
			ST_AN2, ST_ON2: begin
				a_op = op_t'(fb_q);
				b_op = op_t'(fb_q);
			end
			ST_AN3: begin
				a_op = op_t'(limit_q);
				b_op = op_t'(limit_q);
			end
			ST_AN5: begin
				a_op = op_t'(ed_q[31:0]);
				b_op = op_t'(lgain_q);
			end
			ST_AN6: begin
				a_op = op_t'(ed_q[35:32]);
				b_op = op_t'(lgain_q);
			end
			ST_EA1: begin
				a_op = op_t'(res_q);
				b_op = op_t'(ia_q);
			end
			ST_EA2: begin
				a_op = op_t'(res_q);
				b_op = op_t'(ib_q);
			end
			ST_EA3, ST_EA4: begin
				a_op = emf_q;
				b_op = op_t'(per_q);
			end
			ST_EA5: begin
				a_op = op_t'(ld_q);
				b_op = op_t'(ia_q) - op_t'(pia_q);
			end
			ST_TA1: begin
				a_op = op_t'(ld_q);
				b_op = op_t'(ib_q) - op_t'(pib_q);
			end
			ST_OQ1: begin
				a_op = op_t'(iq_q);
				b_op = op_t'(iq_q);
			end
			ST_OQ2: begin
				a_op = op_t'(id_q);
				b_op = op_t'(id_q);
			end
			ST_OQ3: begin
				a_op = op_t'(lq_q) - op_t'(ld_q);
				b_op = op_t'(q2_q);
			end
			ST_OL1: begin
				a_op = op_t'(l8_q);
				b_op = op_t'(ia_q);
			end
			ST_OL2: begin
				a_op = op_t'(l8_q);
				b_op = op_t'(ib_q);
			end
			ST_ON3: begin
				a_op = op_t'(nom_q);
				b_op = op_t'(nom_q);
			end
			ST_OG1: begin
				a_op = op_t'(ogain_q);
				b_op = op_t'(per_q);
			end
			ST_OG3: begin
				a_op = op_t'(ed_q[31:0]);
				b_op = op_t'(gt_q);
			end
			ST_OG4: begin
				a_op = op_t'(ed_q[35:32]);
				b_op = op_t'(gt_q);
			end
			ST_OC1: begin
				a_op = op_t'(fa_q) - op_t'(lia_q);
				b_op = op_t'(f_q);
			end
			ST_OC2: begin
				a_op = op_t'(fb_q) - op_t'(lib_q);
				b_op = op_t'(f_q);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	// Control state, settings and observer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			mode_q    <= MODE_NONE;
			res_q     <= '0;
			ld_q      <= '0;
			lq_q      <= '0;
			per_q     <= PERIOD_RESET;
			nom_q     <= '0;
			lgain_q   <= '0;
			ogain_q   <= '0;
			fa_q      <= '0;
			fb_q      <= '0;
			pia_q     <= '0;
			pib_q     <= '0;
			limit_q   <= '0;
			angle_q   <= '0;
			dcnt_q    <= '0;
		end else begin
			state_q <= state_n;

			// Hold the result beat until taken
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;

			// Register writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MODE:     mode_q  <= obs_mode_t'(cfg_data[1:0]);
					REG_RES:      res_q   <= cfg_data[15:0];
					REG_LD:       ld_q    <= cfg_data[15:0];
					REG_LQ:       lq_q    <= cfg_data[15:0];
					REG_PERIOD:   per_q   <= cfg_data[15:0];
					REG_NOMINAL: begin
						nom_q   <= cfg_data;
						limit_q <= cfg_data;
					end
					REG_LIM_GAIN: lgain_q <= cfg_data[15:0];
					REG_ORT_GAIN: ogain_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_AN7: limit_q <= t_lim[30:0];
				ST_TA1: fa_q <= sat32(wide_t'(fa_q) + wide_t'(ea_q) - t_r3);
				ST_TA2: begin
					fb_q  <= sat32(wide_t'(fb_q) + wide_t'(eb_q) - t_r3);
					pia_q <= ia_q;
					pib_q <= ib_q;
				end
				ST_CL: begin
					fa_q <= fa_cl;
					fb_q <= fb_cl;
				end
				ST_OQ4:  dcnt_q <= '0;
				ST_ODIV: dcnt_q <= dcnt_q + 5'd1;
				ST_OF1: begin
					fa_q <= sat32(wide_t'(fa_q) + wide_t'(ea_q));
					fb_q <= sat32(wide_t'(fb_q) + wide_t'(eb_q));
				end
				ST_OC2:  fa_q <= sat32(wide_t'(fa_q) - t_r32);
				ST_OC3:  fb_q <= sat32(wide_t'(fb_q) - t_r32);
				ST_CWAIT: begin
					if (cor_done)
						angle_q <= cor_angle;
				end
				default: ;
			endcase
		end
	end

	// Work registers and sample latch
	always_ff @(posedge clk) begin
		if (in_fire) begin
			va_q  <= s_axis_tdata[15:0];
			vb_q  <= s_axis_tdata[31:16];
			ia_q  <= s_axis_tdata[47:32];
			ib_q  <= s_axis_tdata[63:48];
			id_q  <= s_axis_tdata[79:64];
			iq_q  <= s_axis_tdata[95:80];
			inj_q <= s_axis_tuser[0];
		end
		if (out_load)
			m_data_q <= {1'b0, angle_q, limit_q, fb_q, fa_q};

		case (state_q)
			ST_AN2, ST_ON2: acc_q <= prod_w;
			ST_AN3, ST_ON3: acc_q <= acc_q + prod_w;
			ST_AN4: begin
				ed_q  <= t_ed[35:0];
				neg_q <= (acc_q < prod_w);
			end
			ST_AN6, ST_OG4: acc_q <= prod_w;
			ST_EA2, ST_EA3: emf_q <= t_emf[32:0];
			ST_EA4: ea_q <= t_r23[26:0];
			ST_EA5: eb_q <= t_r23[26:0];
			ST_OQ2: q2_q <= prod_q[30:0];
			ST_OQ3: begin
				sum_q <= sum_n;
				l8_q  <= $signed({2'b00, ld_q, 8'h00});
			end
			ST_OQ4: begin
				rem_q  <= {1'b0, t_nv[54:24]};
				nlo_q  <= t_nv[23:0];
				dneg_q <= prod_q[65];
				quo_q  <= '0;
			end
			ST_ODIV: begin
				nlo_q <= {nlo_q[22:0], 1'b0};
				if (t_trial >= t_dv) begin
					rem_q <= 32'(t_trial - t_dv);
					quo_q <= {quo_q[22:0], 1'b1};
				end else begin
					rem_q <= t_trial[31:0];
					quo_q <= {quo_q[22:0], 1'b0};
				end
			end
			ST_OADJ: begin
				if (dneg_q)
					l8_q <= $signed({2'b00, ld_q, 8'h00}) - $signed({2'b00, quo_q});
				else
					l8_q <= $signed({2'b00, ld_q, 8'h00}) + $signed({2'b00, quo_q});
			end
			ST_OL2: lia_q <= t_r11[31:0];
			ST_OL3: lib_q <= t_r11[31:0];
			ST_ON4: ed_q <= t_ed[35:0];
			ST_OG2: gt_q <= prod_q[31:0];
			ST_OG5: f_q <= t_f;
			default: ;
		endcase
	end

	// Checks on sequencing
	a_cordic_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_CWAIT))
		else $error("angle unit finished outside its wait step");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after taking a beat");

	a_limit_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AN7) |=> (limit_q >= 31'(FLUX_LIMIT_MIN)))
		else $error("adapted flux limit below its floor");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ODIV) |-> (sum_q != '0))
		else $error("inductance blend divides by zero");

endmodule

// ===== tb/sensorless_flux_observer_checker.sv =====
// Scoreboard for the flux observer: watches the channels, predicts each result beat and compares.
module sensorless_flux_observer_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	input  logic          s_axis_tready,
	input  logic [95:0]   s_axis_tdata,
	input  logic [0:0]    s_axis_tuser,
	input  logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	input  logic [111:0]  m_axis_tdata,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [30:0]   cfg_data,
	output int            fail_count,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import flxobs_pkg::*;

	typedef struct packed {
		logic signed [31:0] flux_a;
		logic signed [31:0] flux_b;
		logic [30:0]        limit;
		logic [15:0]        angle;
	} flux_result_t;

	flux_result_t flux_expected_q[$];

	// Shadow settings
	obs_mode_t mode_r;
	longint res_r, ld_r, lq_r, period_r, nominal_r, lim_gain_r, ort_gain_r;

	// Shadow observer state
	longint flux_a_s, flux_b_s;
	logic [15:0] prev_ia_s, prev_ib_s, angle_s;
	longint limit_s;

	function automatic longint unsigned round_mag(longint unsigned m, int s);
		return (m + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic longint round_shift(longint x, int s);
		if (x < 0)
			return -longint'(round_mag(longint'(-x), s));
		return longint'(round_mag(x, s));
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned mag_sq(longint a, longint b);
		return longint'(a * a) + longint'(b * b);
	endfunction

	// CORDIC vectoring, 2^32 per turn, top 16 bits returned
	function automatic logic [15:0] flux_angle(longint x, longint y);
		logic [31:0] z;
		longint dx, dy;
		z = 32'd0;
		if (x == 0 && y == 0)
			return 16'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += atan_lut(i[4:0]);
			end else begin
				x -= dx;
				y += dy;
				z -= atan_lut(i[4:0]);
			end
		end
		return z[31:16];
	endfunction

	// Back-EMF integral (V - R*I)*T in flux LSBs
	function automatic longint emf_flux(logic signed [15:0] v, logic signed [15:0] i);
		longint emf;
		emf = longint'(v) * 32768 - res_r * longint'(i);
		return round_shift(emf * period_r, 23);
	endfunction

	task automatic adapt_flux_limit();
		longint unsigned norm, lim2;
		longint delta, lim;
		norm = mag_sq(flux_a_s, flux_b_s);
		lim2 = longint'(limit_s * limit_s);
		if (norm >= lim2)
			delta = longint'(round_mag(round_mag(norm - lim2, 28) * lim_gain_r, 16));
		else
			delta = -longint'(round_mag(round_mag(lim2 - norm, 28) * lim_gain_r, 16));
		lim = limit_s + delta;
		if (lim > longint'(FLUX_LIMIT_MAX))
			lim = FLUX_LIMIT_MAX;
		if (lim < longint'(FLUX_LIMIT_MIN))
			lim = FLUX_LIMIT_MIN;
		limit_s = lim & 64'h7FFF_FFFF;
	endtask

	function automatic longint clamp_to_limit(longint f);
		if (f > limit_s)
			return limit_s;
		if (f < -limit_s)
			return -limit_s;
		return f;
	endfunction

	task automatic integrate_clamped(logic signed [15:0] va, logic signed [15:0] vb,
			logic signed [15:0] ia, logic signed [15:0] ib, logic inj);
		longint ta, tb;
		ta = round_shift(ld_r * (longint'(ia) - longint'($signed(prev_ia_s))), 3);
		tb = round_shift(ld_r * (longint'(ib) - longint'($signed(prev_ib_s))), 3);
		flux_a_s = clip32(flux_a_s + emf_flux(va, ia) - ta);
		flux_b_s = clip32(flux_b_s + emf_flux(vb, ib) - tb);
		prev_ia_s = ia;
		prev_ib_s = ib;
		flux_a_s = clamp_to_limit(flux_a_s);
		flux_b_s = clamp_to_limit(flux_b_s);
		if (!inj)
			angle_s = flux_angle(flux_a_s, flux_b_s);
	endtask

	task automatic integrate_ortega(logic signed [15:0] va, logic signed [15:0] vb,
			logic signed [15:0] ia, logic signed [15:0] ib, logic signed [15:0] id,
			logic signed [15:0] iq, logic inj);
		longint unsigned q2, sum, mag, norm, nom2, e, gt, f;
		longint l8, num, adj, lia, lib;
		q2 = longint'(iq) * longint'(iq);
		sum = q2 + longint'(id) * longint'(id);
		l8 = ld_r * 256;
		// Blend Ld toward Lq by iq^2/(2*(id^2+iq^2)); plain Ld with no current
		if (sum != 0) begin
			num = (lq_r - ld_r) * longint'(q2) * 256;
			mag = num < 0 ? longint'(-num) : num;
			adj = longint'((mag + sum) / (2 * sum));
			l8 += num < 0 ? -adj : adj;
		end
		lia = round_shift(l8 * longint'(ia), 11);
		lib = round_shift(l8 * longint'(ib), 11);
		flux_a_s = clip32(flux_a_s + emf_flux(va, ia));
		flux_b_s = clip32(flux_b_s + emf_flux(vb, ib));
		norm = mag_sq(flux_a_s, flux_b_s);
		nom2 = longint'(nominal_r * nominal_r);
		// Pull flux back toward nominal only when it is outside
		if (norm > nom2) begin
			e = round_mag(norm - nom2, 28);
			gt = ort_gain_r * period_r;
			f = 0;
			if (gt != 0 && e != 0) begin
				if (e > (64'd1 << 43) / gt)
					f = F_CAP;
				else begin
					f = round_mag(e * gt, 12);
					if (f > F_CAP)
						f = F_CAP;
				end
			end
			flux_a_s = clip32(flux_a_s - round_shift((flux_a_s - lia) * longint'(f), 32));
			flux_b_s = clip32(flux_b_s - round_shift((flux_b_s - lib) * longint'(f), 32));
		end
		if (!inj)
			angle_s = flux_angle(flux_a_s - lia, flux_b_s - lib);
	endtask

	task automatic predict_flux(logic [95:0] d, logic inj);
		flux_result_t r;
		case (mode_r)
			MODE_ADAPT: begin
				adapt_flux_limit();
				integrate_clamped(d[15:0], d[31:16], d[47:32], d[63:48], inj);
			end
			MODE_CLAMP: integrate_clamped(d[15:0], d[31:16], d[47:32], d[63:48], inj);
			MODE_ORTEGA: integrate_ortega(d[15:0], d[31:16], d[47:32], d[63:48],
				d[79:64], d[95:80], inj);
			default: ;
		endcase
		r.flux_a = flux_a_s[31:0];
		r.flux_b = flux_b_s[31:0];
		r.limit = limit_s[30:0];
		r.angle = angle_s;
		flux_expected_q.push_back(r);
	endtask

	task automatic compare_flux(logic [111:0] d);
		flux_result_t exp_r;
		if (flux_expected_q.size() == 0) begin
			$error("result beat with no input waiting: %h", d);
			fail_count++;
			return;
		end
		exp_r = flux_expected_q.pop_front();
		if (d[31:0] !== exp_r.flux_a) begin
			$error("flux_alpha_out expected %0d actual %0d", exp_r.flux_a, $signed(d[31:0]));
			fail_count++;
		end
		if (d[63:32] !== exp_r.flux_b) begin
			$error("flux_beta_out expected %0d actual %0d", exp_r.flux_b, $signed(d[63:32]));
			fail_count++;
		end
		if (d[94:64] !== exp_r.limit) begin
			$error("flux_limit_out expected %0d actual %0d", exp_r.limit, d[94:64]);
			fail_count++;
		end
		if (d[110:95] !== exp_r.angle) begin
			$error("rotor_angle expected %0d actual %0d", exp_r.angle, d[110:95]);
			fail_count++;
		end
	endtask

	assign pending = flux_expected_q.size();

	// Track settings and beats on every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = MODE_NONE;
			res_r = 0;
			ld_r = 0;
			lq_r = 0;
			period_r = PERIOD_RESET;
			nominal_r = 0;
			lim_gain_r = 0;
			ort_gain_r = 0;
			flux_a_s = 0;
			flux_b_s = 0;
			prev_ia_s = '0;
			prev_ib_s = '0;
			angle_s = '0;
			limit_s = 0;
			fail_count = 0;
			flux_expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MODE:     mode_r = obs_mode_t'(cfg_data[1:0]);
					REG_RES:      res_r = cfg_data[15:0];
					REG_LD:       ld_r = cfg_data[15:0];
					REG_LQ:       lq_r = cfg_data[15:0];
					REG_PERIOD:   period_r = cfg_data[15:0];
					REG_NOMINAL: begin
						nominal_r = cfg_data;
						limit_s = cfg_data;
					end
					REG_LIM_GAIN: lim_gain_r = cfg_data[15:0];
					REG_ORT_GAIN: ort_gain_r = cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				compare_flux(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				predict_flux(s_axis_tdata, s_axis_tuser[0]);
		end
	end

endmodule

// ===== tb/sensorless_flux_observer_core_tb.sv =====
// Top of the flux observer testbench: clock, reset, stimulus, settings phases and verdict.
module sensorless_flux_observer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import flxobs_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES  = 8;
	localparam int SETTLE      = 120;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [30:0]  cfg_data;
	int           fail_count;
	int           pending;
	int           cycle_count;
	int           beats_sent;
	logic         long_hold_req;

	typedef struct {
		obs_mode_t mode;
		int unsigned res, ld, lq, period, nominal, lim_gain, ort_gain, beats;
	} obs_setting_t;

	obs_setting_t phases [NUM_PHASES];

	sensorless_flux_observer_core dut (.*);

	sensorless_flux_observer_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
				long_hold_req = 1'b0;
			end
			if ($urandom_range(0, 9) < 6)
				m_axis_tready = 1'b1;
			else
				m_axis_tready = ($urandom_range(0, 19) == 0) ? 1'b0 : 1'b0;
			if (!m_axis_tready && $urandom_range(0, 15) == 0)
				repeat ($urandom_range(10, 60)) @(negedge clk);
		end
	end

	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: return 16'($signed($urandom_range(0, 400)) - 200);
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[30:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Offer one beat at a falling edge and hold it until taken
	task automatic send_beat(logic [15:0] va, logic [15:0] vb, logic [15:0] ia,
			logic [15:0] ib, logic [15:0] id, logic [15:0] iq, logic inj);
		int gap;
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {iq, id, ib, ia, vb, va};
		s_axis_tuser = inj;
		while (!s_axis_tready)
			@(negedge clk);
		@(negedge clk);
		beats_sent++;
		gap = ($urandom_range(0, 9) < 4) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4));
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random();
		send_beat(pick_field(), pick_field(), pick_field(), pick_field(),
			pick_field(), pick_field(), $urandom_range(0, 3) == 0);
	endtask

	task automatic apply_setting(obs_setting_t p);
		write_reg(REG_MODE, p.mode);
		write_reg(REG_RES, p.res);
		write_reg(REG_LD, p.ld);
		write_reg(REG_LQ, p.lq);
		write_reg(REG_PERIOD, p.period);
		write_reg(REG_NOMINAL, p.nominal);
		write_reg(REG_LIM_GAIN, p.lim_gain);
		write_reg(REG_ORT_GAIN, p.ort_gain);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycle_count = 0;
		beats_sent = 0;
		long_hold_req = 1'b0;
		phases[0] = '{MODE_CLAMP, 1000, 2000, 0, 13422, 32'h0800_0000, 0, 0, 70};
		phases[1] = '{MODE_ADAPT, 65535, 65535, 65535, 65535, 32'h7FFF_FFFF, 65535, 0, 80};
		phases[2] = '{MODE_ADAPT, 0, 0, 0, 1, 0, 300, 0, 75};
		phases[3] = '{MODE_ORTEGA, 3000, 500, 1500, 13422, 32'h0100_0000, 100, 100, 80};
		phases[4] = '{MODE_ORTEGA, 65535, 60000, 10, 65535, 0, 0, 65535, 80};
		phases[5] = '{MODE_CLAMP, 400, 300, 0, 0, 32'h1000_0000, 0, 0, 60};
		phases[6] = '{MODE_ORTEGA, 200, 0, 65535, 20000, 32'h0040_0000, 0, 0, 70};
		phases[7] = '{MODE_NONE, 1, 1, 1, 13422, 5, 1, 1, 60};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Mode none after reset: everything held at zero
		send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 1'b0);
		send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			apply_setting(phases[p]);
			if (p == 0) begin
				// Field extremes, injection on and off, clamping from both sides
				send_beat(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0, 16'h0, 1'b0);
				send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 1'b1);
				send_beat(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 1'b0);
				send_beat(16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
				send_beat(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
				send_beat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h0, 16'h0, 1'b1);
			end
			if (p == 1)
				long_hold_req = 1'b1;
			if (p == 3) begin
				// Ortega with no d/q current, then pure d and pure q current
				send_beat(16'h4000, 16'hC000, 16'h0100, 16'h0100, 16'h0, 16'h0, 1'b0);
				send_beat(16'h4000, 16'h4000, 16'h0100, 16'h0100, 16'h8000, 16'h0, 1'b0);
				send_beat(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0, 16'h7FFF, 1'b0);
				send_beat(16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 16'h7FFF, 16'h8000, 1'b1);
				send_beat(16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 1'b0);
			end
			for (int n = 0; n < phases[p].beats; n++)
				send_random();
			drain();
		end

		$display("Sent %0d beats through modes none, clamp, adaptive limit and Ortega,",
			beats_sent);
		$display("with extreme settings, zero period, injection and a long output stall.");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sensorless_flux_observer_core.f =====
hdl/flxobs_pkg.sv
hdl/flxobs_mul.sv
hdl/flxobs_cordic.sv
hdl/sensorless_flux_observer_core.sv
tb/sensorless_flux_observer_checker.sv
tb/sensorless_flux_observer_core_tb.sv
